>>> design/sgcbm_pkg.sv
`default_nettype none

package sgcbm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W = 16;
    localparam int GAIN_FRAC = 12;
    localparam int COEF_W = 19;
    localparam int DATA_W = 18;
    localparam int PROD_W = COEF_W + DATA_W;
    localparam int ACC_W = PROD_W + 3;
    localparam int PEAK_W = 15;
    localparam int SQ_W = 2 * PEAK_W;
    localparam int SUM_W = 38;
    localparam int COUNT_W = 9;
    localparam int CFG_IDX_W = 3;

    localparam int MAX_BLOCK_FRAMES_DEF = 256;
    localparam int COEF_FRAC_BITS_DEF = 16;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;
    localparam logic signed [SAMPLE_W-1:0] CLIP_MAX = 16'sd32767;
    localparam logic signed [SAMPLE_W-1:0] CLIP_MIN = -16'sd32767;
    localparam logic signed [DATA_W-1:0] Y_MAX = 18'sd131071;
    localparam logic signed [DATA_W-1:0] Y_MIN = -18'sd131072;
    localparam logic signed [DATA_W-1:0] OUT_MAX = 18'sd32767;
    localparam logic signed [DATA_W-1:0] OUT_MIN = -18'sd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MONO_INPUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B2 = 3'd6;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_GAIN,
        SQ_CLAMP,
        SQ_T0,
        SQ_T1,
        SQ_T2,
        SQ_T3,
        SQ_T4,
        SQ_FIN,
        SQ_DONE,
        SQ_MID,
        SQ_SQR,
        SQ_COMMIT
    } seq_t;

    typedef struct packed {
        logic load;
        seq_t step;
    } lane_ctl_t;

    typedef struct packed {
        seq_t step;
        logic commit;
        logic last;
    } meter_ctl_t;

    typedef struct packed {
        logic done;
        logic [PEAK_W-1:0] peak;
        logic [SUM_W-1:0] sum;
        logic [COUNT_W-1:0] count;
    } meter_res_t;

endpackage

`default_nettype wire

>>> design/stereo_gain_clip_biquad_meter.sv
// stereo gain, clip, low-pass biquad and block level meter
//
// input channel: in_valid/in_ready with left_in, right_in, last_in_block; one stereo
// frame per item. output channel: out_valid/out_ready with the processed samples and
// the meter fields, which are zero unless block_done is set.
// configuration: cfg_we writes cfg_data into register cfg_index at the clock edge
// (0 gain, 1 filter_enable, 2 mono_input, 3..6 coefficients); write only while idle.
// each channel has its own lane with one 19x18 multiplier, used once for the gain and
// five times for the biquad terms; a meter stage then forms the mid value, squares it
// and updates the running block figures.
// sequence: gain, clamp, the five biquad terms t0..t4, fin, done, mid, sqr and commit;
// out_valid is registered at commit, and in_ready stays low until the sequence is back
// at idle, so a new item is taken only once the last one has been committed.
// a stalled receiver holds the result in the output register; the next item still
// runs through the lanes and waits at the final step until the register frees.
// reset: gain 1.0, filter off, stereo input, coefficients, filter history and meter
// totals cleared, no result pending.

`default_nettype none

module stereo_gain_clip_biquad_meter
    import sgcbm_pkg::*;
#(
    parameter int MAX_BLOCK_FRAMES = MAX_BLOCK_FRAMES_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [COEF_W-1:0]          cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [SAMPLE_W-1:0] left_in,
    input  wire logic signed [SAMPLE_W-1:0] right_in,
    input  wire logic                       last_in_block,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [SAMPLE_W-1:0]      left_out,
    output logic signed [SAMPLE_W-1:0]      right_out,
    output logic                            block_done,
    output logic [PEAK_W-1:0]               block_peak,
    output logic [SUM_W-1:0]                block_sum_squares,
    output logic [COUNT_W-1:0]              block_count
);

    logic [GAIN_W-1:0]        gain_reg;
    logic                     filter_enable_reg;
    logic                     mono_input_reg;
    logic signed [COEF_W-1:0] coef_a0_reg, coef_a1_reg, coef_b1_reg, coef_b2_reg;

    seq_t state_reg, state_next;
    logic last_reg;
    logic accept;
    logic commit;

    logic out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] left_out_reg, right_out_reg;
    meter_res_t res_reg;

    lane_ctl_t lane_ctl;
    meter_ctl_t meter_ctl;
    meter_res_t meter_res;
    logic signed [SAMPLE_W-1:0] right_src;
    logic signed [SAMPLE_W-1:0] left_y, right_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg          <= GAIN_RESET;
            filter_enable_reg <= 1'b0;
            mono_input_reg    <= 1'b0;
            coef_a0_reg       <= '0;
            coef_a1_reg       <= '0;
            coef_b1_reg       <= '0;
            coef_b2_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAIN:          gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_FILTER_ENABLE: filter_enable_reg <= cfg_data[0];
                CFG_MONO_INPUT:    mono_input_reg <= cfg_data[0];
                CFG_COEF_A0:       coef_a0_reg <= cfg_data;
                CFG_COEF_A1:       coef_a1_reg <= cfg_data;
                CFG_COEF_B1:       coef_b1_reg <= cfg_data;
                CFG_COEF_B2:       coef_b2_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign in_ready = (state_reg == SQ_IDLE);
    assign accept   = in_valid && in_ready;
    assign commit   = (state_reg == SQ_COMMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SQ_IDLE:   if (accept) state_next = SQ_GAIN;
            SQ_GAIN:   state_next = SQ_CLAMP;
            SQ_CLAMP:  state_next = SQ_T0;
            SQ_T0:     state_next = SQ_T1;
            SQ_T1:     state_next = SQ_T2;
            SQ_T2:     state_next = SQ_T3;
            SQ_T3:     state_next = SQ_T4;
            SQ_T4:     state_next = SQ_FIN;
            SQ_FIN:    state_next = SQ_DONE;
            SQ_DONE:   state_next = SQ_MID;
            SQ_MID:    state_next = SQ_SQR;
            SQ_SQR:    state_next = SQ_COMMIT;
            SQ_COMMIT: if (commit) state_next = SQ_IDLE;
            default:   state_next = SQ_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SQ_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= last_in_block;
        end
        if (commit)
        begin
            left_out_reg  <= left_y;
            right_out_reg <= right_y;
            res_reg       <= meter_res;
        end
    end

    assign right_src = mono_input_reg ? left_in : right_in;

    assign lane_ctl.load = accept;
    assign lane_ctl.step = state_reg;

    assign meter_ctl.step   = state_reg;
    assign meter_ctl.commit = commit;
    assign meter_ctl.last   = last_reg;

    sgcbm_lane #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_left (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (lane_ctl),
        .x             (left_in),
        .gain          (gain_reg),
        .filter_enable (filter_enable_reg),
        .coef_a0       (coef_a0_reg),
        .coef_a1       (coef_a1_reg),
        .coef_b1       (coef_b1_reg),
        .coef_b2       (coef_b2_reg),
        .y             (left_y)
    );

    sgcbm_lane #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_right (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (lane_ctl),
        .x             (right_src),
        .gain          (gain_reg),
        .filter_enable (filter_enable_reg),
        .coef_a0       (coef_a0_reg),
        .coef_a1       (coef_a1_reg),
        .coef_b1       (coef_b1_reg),
        .coef_b2       (coef_b2_reg),
        .y             (right_y)
    );

    sgcbm_meter #(
        .MAX_BLOCK_FRAMES (MAX_BLOCK_FRAMES)
    ) u_meter (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (meter_ctl),
        .left_y  (left_y),
        .right_y (right_y),
        .res     (meter_res)
    );

    assign out_valid         = out_valid_reg;
    assign left_out          = left_out_reg;
    assign right_out         = right_out_reg;
    assign block_done        = res_reg.done;
    assign block_peak        = res_reg.peak;
    assign block_sum_squares = res_reg.sum;
    assign block_count       = res_reg.count;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == SQ_GAIN)
        else $error("accepted item did not start the lane sequence");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid)
        else $error("committed item not presented");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SQ_COMMIT) && out_valid_reg && !out_ready |=> state_reg == SQ_COMMIT)
        else $error("item left the final step while the output was full");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != SQ_IDLE) |-> !in_ready)
        else $error("input taken while an item is in flight");

    a_meter_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !block_done |->
            block_peak == '0 && block_sum_squares == '0 && block_count == '0)
        else $error("meter fields set on an unfinished block");

endmodule

`default_nettype wire

>>> design/sgcbm_lane.sv
`default_nettype none

module sgcbm_lane
    import sgcbm_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire lane_ctl_t                  ctl,
    input  wire logic signed [SAMPLE_W-1:0] x,
    input  wire logic [GAIN_W-1:0]          gain,
    input  wire logic                       filter_enable,
    input  wire logic signed [COEF_W-1:0]   coef_a0,
    input  wire logic signed [COEF_W-1:0]   coef_a1,
    input  wire logic signed [COEF_W-1:0]   coef_b1,
    input  wire logic signed [COEF_W-1:0]   coef_b2,
    output logic signed [SAMPLE_W-1:0]      y
);

    localparam logic signed [PROD_W-1:0] GAIN_BIAS = PROD_W'((64'sd1 <<< GAIN_FRAC) - 64'sd1);
    localparam logic signed [ACC_W-1:0] ROUND_BIAS =
        ACC_W'((64'sd1 <<< COEF_FRAC_BITS) - 64'sd1);

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] g_reg, g_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [SAMPLE_W-1:0] xh1_reg, xh2_reg;
    logic signed [DATA_W-1:0]   yh1_reg, yh2_reg;
    logic signed [SAMPLE_W-1:0] y_reg, y_next;

    logic signed [COEF_W-1:0]   mult_a;
    logic signed [DATA_W-1:0]   mult_b;
    logic signed [PROD_W-1:0]   mult_p;
    logic                       mult_en;
    logic signed [PROD_W-1:0]   gain_q;
    logic signed [ACC_W-1:0]    acc_q;
    logic signed [DATA_W-1:0]   y_full;
    logic signed [ACC_W-1:0]    prod_ext;

    // one shared multiplier, operands picked by the sequencer step
    always_comb
    begin
        mult_a  = '0;
        mult_b  = '0;
        mult_en = 1'b1;
        case (ctl.step)
            SQ_GAIN:
            begin
                mult_a = COEF_W'({1'b0, gain});
                mult_b = DATA_W'(x_reg);
            end
            SQ_T0:
            begin
                mult_a = coef_a0;
                mult_b = DATA_W'(g_reg);
            end
            SQ_T1:
            begin
                mult_a = coef_a1;
                mult_b = DATA_W'(xh1_reg);
            end
            SQ_T2:
            begin
                mult_a = coef_a0;
                mult_b = DATA_W'(xh2_reg);
            end
            SQ_T3:
            begin
                mult_a = coef_b1;
                mult_b = yh1_reg;
            end
            SQ_T4:
            begin
                mult_a = coef_b2;
                mult_b = yh2_reg;
            end
            default:
            begin
                mult_en = 1'b0;
            end
        endcase
    end

    assign mult_p = mult_a * mult_b;
    assign prod_ext = ACC_W'(prod_reg);

    // divide by 4096 (gain) or by 2^COEF_FRAC_BITS (filter), rounding toward zero
    assign gain_q = (prod_reg + (prod_reg[PROD_W-1] ? GAIN_BIAS : PROD_W'(0))) >>> GAIN_FRAC;
    assign acc_q = (acc_reg + (acc_reg[ACC_W-1] ? ROUND_BIAS : ACC_W'(0))) >>> COEF_FRAC_BITS;

    always_comb
    begin
        if (acc_q > ACC_W'(Y_MAX))
        begin
            y_full = Y_MAX;
        end
        else if (acc_q < ACC_W'(Y_MIN))
        begin
            y_full = Y_MIN;
        end
        else
        begin
            y_full = DATA_W'(acc_q);
        end
    end

    always_comb
    begin
        g_next   = g_reg;
        acc_next = acc_reg;
        y_next   = y_reg;
        case (ctl.step)
            SQ_CLAMP:
            begin
                if (gain_q > PROD_W'(CLIP_MAX))
                begin
                    g_next = CLIP_MAX;
                end
                else if (gain_q < PROD_W'(CLIP_MIN))
                begin
                    g_next = CLIP_MIN;
                end
                else
                begin
                    g_next = SAMPLE_W'(gain_q);
                end
            end
            SQ_T1:   acc_next = prod_ext;
            SQ_T2:   acc_next = acc_reg + prod_ext;
            SQ_T3:   acc_next = acc_reg + prod_ext;
            SQ_T4:   acc_next = acc_reg - prod_ext;
            SQ_FIN:  acc_next = acc_reg - prod_ext;
            SQ_DONE:
            begin
                if (!filter_enable)
                begin
                    y_next = g_reg;
                end
                else if (y_full > OUT_MAX)
                begin
                    y_next = SAMPLE_W'(OUT_MAX);
                end
                else if (y_full < OUT_MIN)
                begin
                    y_next = SAMPLE_W'(OUT_MIN);
                end
                else
                begin
                    y_next = SAMPLE_W'(y_full);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            x_reg <= x;
        end
        if (mult_en)
        begin
            prod_reg <= mult_p;
        end
        g_reg   <= g_next;
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xh1_reg <= '0;
            xh2_reg <= '0;
            yh1_reg <= '0;
            yh2_reg <= '0;
            y_reg   <= '0;
        end
        else
        begin
            y_reg <= y_next;
            // history only moves while the filter is in use
            if (ctl.step == SQ_DONE && filter_enable)
            begin
                xh2_reg <= xh1_reg;
                xh1_reg <= g_reg;
                yh2_reg <= yh1_reg;
                yh1_reg <= y_full;
            end
        end
    end

    assign y = y_reg;

endmodule

`default_nettype wire

>>> design/sgcbm_meter.sv
`default_nettype none

module sgcbm_meter
    import sgcbm_pkg::*;
#(
    parameter int MAX_BLOCK_FRAMES = MAX_BLOCK_FRAMES_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire meter_ctl_t                 ctl,
    input  wire logic signed [SAMPLE_W-1:0] left_y,
    input  wire logic signed [SAMPLE_W-1:0] right_y,
    output meter_res_t                      res
);

    localparam int CNT_W = $clog2(MAX_BLOCK_FRAMES + 1);

    logic [PEAK_W-1:0] mid_reg, mid_next;
    logic [SQ_W-1:0]   sq_reg;
    logic [PEAK_W-1:0] peak_reg, peak_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic signed [SAMPLE_W:0] lr_sum;
    logic [SAMPLE_W:0]        lr_abs;
    logic [SAMPLE_W-1:0]      lr_half;
    logic [PEAK_W-1:0]        peak_upd;
    logic [SUM_W-1:0]         sum_upd;
    logic [CNT_W-1:0]         count_upd;
    logic                     done;

    // mid = |l + r| / 2, saturated to 15 bits
    assign lr_sum  = (SAMPLE_W+1)'(left_y) + (SAMPLE_W+1)'(right_y);
    assign lr_abs  = lr_sum[SAMPLE_W] ? (SAMPLE_W+1)'(-lr_sum) : (SAMPLE_W+1)'(lr_sum);
    assign lr_half = lr_abs[SAMPLE_W:1];
    assign mid_next = lr_half[SAMPLE_W-1] ? {PEAK_W{1'b1}} : lr_half[PEAK_W-1:0];

    assign peak_upd  = (mid_reg > peak_reg) ? mid_reg : peak_reg;
    assign sum_upd   = sum_reg + SUM_W'(sq_reg);
    assign count_upd = count_reg + 1'b1;
    assign done      = ctl.last || (count_upd >= CNT_W'(MAX_BLOCK_FRAMES));

    always_comb
    begin
        peak_next  = peak_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        res        = '0;
        if (ctl.step == SQ_COMMIT)
        begin
            if (done)
            begin
                res.done  = 1'b1;
                res.peak  = peak_upd;
                res.sum   = sum_upd;
                res.count = COUNT_W'(count_upd);
            end
            if (ctl.commit)
            begin
                peak_next  = done ? '0 : peak_upd;
                sum_next   = done ? '0 : sum_upd;
                count_next = done ? '0 : count_upd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step == SQ_MID)
        begin
            mid_reg <= mid_next;
        end
        if (ctl.step == SQ_SQR)
        begin
            sq_reg <= mid_reg * mid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg  <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            peak_reg  <= peak_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> tb/sgcbm_frame_checker.sv
`default_nettype none

module sgcbm_frame_checker
    import sgcbm_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [COEF_W-1:0]          cfg_data,
    input  wire logic                       in_valid,
    input  wire logic                       in_ready,
    input  wire logic signed [SAMPLE_W-1:0] left_in,
    input  wire logic signed [SAMPLE_W-1:0] right_in,
    input  wire logic                       last_in_block,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire logic signed [SAMPLE_W-1:0] left_out,
    input  wire logic signed [SAMPLE_W-1:0] right_out,
    input  wire logic                       block_done,
    input  wire logic [PEAK_W-1:0]          block_peak,
    input  wire logic [SUM_W-1:0]           block_sum_squares,
    input  wire logic [COUNT_W-1:0]         block_count,
    output int                              mismatches,
    output int                              outstanding
);

    typedef struct packed {
        logic [SAMPLE_W-1:0] left_s;
        logic [SAMPLE_W-1:0] right_s;
        logic                done;
        logic [PEAK_W-1:0]   peak;
        logic [SUM_W-1:0]    sum_sq;
        logic [COUNT_W-1:0]  frames;
    } frame_out_t;

    longint gain_q;
    longint a0;
    longint a1;
    longint b1;
    longint b2;
    logic   filt_on;
    logic   mono_on;

    // per channel pair: [n-1], [n-2]; left at 0..1, right at 2..3
    longint x_hist [4];
    longint y_hist [4];
    longint peak_run;
    longint sum_run;
    longint count_run;

    frame_out_t pending_frames [$];

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic longint lane(input longint x, input int ch);
        longint g;
        longint acc;
        longint y;
        int     i0;
        i0 = 2 * ch;
        g = clip(x * gain_q / (longint'(1) << GAIN_FRAC), CLIP_MIN, CLIP_MAX);
        if (filt_on)
        begin
            acc = a0 * g + a1 * x_hist[i0] + a0 * x_hist[i0+1]
                - b1 * y_hist[i0] - b2 * y_hist[i0+1];
            y = clip(acc / (longint'(1) << COEF_FRAC_BITS_DEF), Y_MIN, Y_MAX);
            x_hist[i0+1] = x_hist[i0];
            x_hist[i0] = g;
            y_hist[i0+1] = y_hist[i0];
            y_hist[i0] = y;
            g = y;
        end
        return clip(g, OUT_MIN, OUT_MAX);
    endfunction

    function automatic frame_out_t gain_filter_meter(input logic signed [SAMPLE_W-1:0] l_in,
                                                     input logic signed [SAMPLE_W-1:0] r_in,
                                                     input logic last);
        frame_out_t res;
        longint     lo;
        longint     ro;
        longint     s;
        longint     mid;
        lo = lane(longint'(l_in), 0);
        ro = lane(mono_on ? longint'(l_in) : longint'(r_in), 1);
        s = lo + ro;
        if (s < 0)
            s = -s;
        mid = clip(s / 2, 0, (longint'(1) << PEAK_W) - 1);
        if (mid > peak_run)
            peak_run = mid;
        sum_run += mid * mid;
        count_run++;
        res.left_s = lo[SAMPLE_W-1:0];
        res.right_s = ro[SAMPLE_W-1:0];
        // a full block closes even without the marker
        res.done = last || (count_run >= MAX_BLOCK_FRAMES_DEF);
        if (res.done)
        begin
            res.peak = peak_run[PEAK_W-1:0];
            res.sum_sq = sum_run[SUM_W-1:0];
            res.frames = count_run[COUNT_W-1:0];
            peak_run = 0;
            sum_run = 0;
            count_run = 0;
        end
        else
        begin
            res.peak = '0;
            res.sum_sq = '0;
            res.frames = '0;
        end
        return res;
    endfunction

    task automatic check_field(input string what, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_out_t want;
        if (!rst_n)
        begin
            gain_q = longint'(GAIN_RESET);
            filt_on = 1'b0;
            mono_on = 1'b0;
            a0 = 0;
            a1 = 0;
            b1 = 0;
            b2 = 0;
            for (int i = 0; i < 4; i++)
            begin
                x_hist[i] = 0;
                y_hist[i] = 0;
            end
            peak_run = 0;
            sum_run = 0;
            count_run = 0;
            pending_frames.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GAIN:          gain_q = longint'(cfg_data[GAIN_W-1:0]);
                    CFG_FILTER_ENABLE: filt_on = cfg_data[0];
                    CFG_MONO_INPUT:    mono_on = cfg_data[0];
                    CFG_COEF_A0:       a0 = longint'($signed(cfg_data));
                    CFG_COEF_A1:       a1 = longint'($signed(cfg_data));
                    CFG_COEF_B1:       b1 = longint'($signed(cfg_data));
                    CFG_COEF_B2:       b2 = longint'($signed(cfg_data));
                    default:           ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (pending_frames.size() == 0)
                begin
                    $display("%0t: output item with none expected, left %0d right %0d",
                             $time, left_out, right_out);
                    mismatches++;
                end
                else
                begin
                    want = pending_frames.pop_front();
                    check_field("left_out", $signed(want.left_s), left_out);
                    check_field("right_out", $signed(want.right_s), right_out);
                    check_field("block_done", want.done, block_done);
                    check_field("block_peak", want.peak, block_peak);
                    check_field("block_sum_squares", want.sum_sq, block_sum_squares);
                    check_field("block_count", want.frames, block_count);
                end
            end
            if (in_valid && in_ready)
                pending_frames.push_back(gain_filter_meter(left_in, right_in, last_in_block));
            outstanding = pending_frames.size();
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_stereo_gain_clip_biquad_meter.sv
`default_nettype none

module tb_stereo_gain_clip_biquad_meter;
    import sgcbm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;
    localparam int CYCLE_LIMIT = 300000;

    // low-pass near an eighth of the sample rate, and a deliberately unstable set
    localparam logic [COEF_W-1:0] LP_A0 = 19'sd6397;
    localparam logic [COEF_W-1:0] LP_A1 = 19'sd12796;
    localparam logic [COEF_W-1:0] LP_B1 = -19'sd61787;
    localparam logic [COEF_W-1:0] LP_B2 = 19'sd21845;
    localparam logic [COEF_W-1:0] COEF_TOP = 19'h3FFFF;
    localparam logic [COEF_W-1:0] COEF_BOTTOM = 19'h40000;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [COEF_W-1:0]          cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic                       last_in_block;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       block_done;
    logic [PEAK_W-1:0]          block_peak;
    logic [SUM_W-1:0]           block_sum_squares;
    logic [COUNT_W-1:0]         block_count;

    int mismatches;
    int outstanding;
    int idle_pct = 0;
    int stall_pct = 0;
    int cycles = 0;

    stereo_gain_clip_biquad_meter dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .left_in           (left_in),
        .right_in          (right_in),
        .last_in_block     (last_in_block),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .left_out          (left_out),
        .right_out         (right_out),
        .block_done        (block_done),
        .block_peak        (block_peak),
        .block_sum_squares (block_sum_squares),
        .block_count       (block_count)
    );

    sgcbm_frame_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .left_in           (left_in),
        .right_in          (right_in),
        .last_in_block     (last_in_block),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .left_out          (left_out),
        .right_out         (right_out),
        .block_done        (block_done),
        .block_peak        (block_peak),
        .block_sum_squares (block_sum_squares),
        .block_count       (block_count),
        .mismatches        (mismatches),
        .outstanding       (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("stereo_gain_clip_biquad_meter test failed");
            $finish;
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // called just after a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_setup(input logic [GAIN_W-1:0] gain, input logic filt,
                              input logic mono, input logic [COEF_W-1:0] c_a0,
                              input logic [COEF_W-1:0] c_a1, input logic [COEF_W-1:0] c_b1,
                              input logic [COEF_W-1:0] c_b2);
        write_reg(CFG_GAIN, COEF_W'(gain));
        write_reg(CFG_FILTER_ENABLE, COEF_W'(filt));
        write_reg(CFG_MONO_INPUT, COEF_W'(mono));
        write_reg(CFG_COEF_A0, c_a0);
        write_reg(CFG_COEF_A1, c_a1);
        write_reg(CFG_COEF_B1, c_b1);
        write_reg(CFG_COEF_B2, c_b2);
    endtask

    // let every item in flight come out before touching the registers
    task automatic wait_for_quiet();
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
                              input logic signed [SAMPLE_W-1:0] r, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        left_in = l;
        right_in = r;
        last_in_block = last;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        int                  items;
        int                  last_pct;
        logic [GAIN_W-1:0]   gain;
        logic [COEF_W-1:0]   c [4];
        logic                filt;
        logic                mono;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_GAIN;
        cfg_data = '0;
        in_valid = 1'b0;
        left_in = '0;
        right_in = '0;
        last_in_block = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset setup: unity gain, no filter, stereo
        send_frame(16'sh7FFF, 16'sh8000, 1'b0);
        send_frame(16'sh8000, 16'sh8000, 1'b0);
        send_frame(16'sh0000, 16'sh0000, 1'b1);
        send_frame(16'shFFFF, 16'sh0001, 1'b1);
        send_frame(16'sh3039, 16'sh7FFF, 1'b0);

        // full gain into the clamp, right ignored
        wait_for_quiet();
        load_setup(16'hFFFF, 1'b0, 1'b1, '0, '0, '0, '0);
        send_frame(16'sh7FFF, 16'sh1234, 1'b0);
        send_frame(16'sh8000, 16'sh7FFF, 1'b0);
        send_frame(16'sh0001, 16'sh8000, 1'b1);

        wait_for_quiet();
        load_setup(16'h0000, 1'b0, 1'b0, '0, '0, '0, '0);
        send_frame(16'sh7FFF, 16'sh8000, 1'b1);

        // extreme coefficients drive both saturation stages
        wait_for_quiet();
        load_setup(GAIN_RESET, 1'b1, 1'b0, COEF_TOP, COEF_BOTTOM, COEF_BOTTOM, COEF_TOP);
        send_frame(16'sh7FFF, 16'sh8000, 1'b0);
        send_frame(16'sh8000, 16'sh7FFF, 1'b0);
        send_frame(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_frame(16'sh0000, 16'sh0000, 1'b0);
        send_frame(16'sh8000, 16'sh8000, 1'b1);

        // bypass holds the filter history
        wait_for_quiet();
        write_reg(CFG_FILTER_ENABLE, '0);
        send_frame(16'sh03E8, 16'shFC18, 1'b0);

        wait_for_quiet();
        write_reg(CFG_NONE, 19'h7FFFF);
        load_setup(GAIN_RESET, 1'b1, 1'b0, LP_A0, LP_A1, LP_B1, LP_B2);
        send_frame(16'sh4000, 16'shC000, 1'b0);
        send_frame(16'sh4000, 16'shC000, 1'b0);
        send_frame(16'sh0000, 16'sh7FFF, 1'b0);
        send_frame(16'sh8000, 16'sh0000, 1'b1);

        for (int phase = 0; phase < 7; phase++)
        begin
            wait_for_quiet();
            case (phase % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 52; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            case ($urandom_range(3))
                0:       gain = 16'hFFFF;
                1:       gain = GAIN_RESET;
                2:       gain = 16'($urandom_range(8191));
                default: gain = 16'($urandom);
            endcase
            case ($urandom_range(2))
                0:       c = '{LP_A0, LP_A1, LP_B1, LP_B2};
                1:       c = '{COEF_TOP, COEF_BOTTOM, COEF_BOTTOM, COEF_TOP};
                default: c = '{19'($urandom), 19'($urandom), 19'($urandom), 19'($urandom)};
            endcase
            filt = ($urandom_range(3) != 0);
            mono = ($urandom_range(3) == 0);
            items = 55;
            last_pct = 4;
            if (phase == 6)
            begin
                // one long stretch with no marker so a block fills up, near full scale
                items = 270;
                last_pct = 0;
                gain = 16'hFFFF;
                filt = 1'b0;
                mono = 1'b1;
            end
            write_reg(CFG_NONE, 19'($urandom));
            load_setup(gain, filt, mono, c[0], c[1], c[2], c[3]);
            for (int n = 0; n < items; n++)
                send_frame(pick_sample(), pick_sample(), $urandom_range(99) < last_pct);
        end

        wait_for_quiet();
        if (mismatches == 0)
            $display("stereo_gain_clip_biquad_meter test passed");
        else
            $display("stereo_gain_clip_biquad_meter test failed");
        $finish;
    end

endmodule

`default_nettype wire
